FILE: rtl/dzv_pkg.sv
// Shared widths, register indexes, stream constants and types for the
// delta, zigzag and varint block encoder. No dependencies.
package dzv_pkg;

  localparam int VAL_W     = 16;
  localparam int PRED_W    = 20;
  localparam int DIFF_W    = 21;
  localparam int Q_W       = 21;
  localparam int Z_W       = 21;
  localparam int STEP_W    = 8;
  localparam int RECIP_W   = 9;
  localparam int PROD_W    = 31;
  localparam int SHIFT_W   = PROD_W - 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CH_N      = 6;
  localparam int CH_W      = 3;
  localparam int GRP_W     = 2;
  localparam int GRP_N     = 4;
  localparam int BYTE_W    = 8;
  localparam int SMALL_W   = 5;

  localparam logic [PROD_W-1:0] ROUND_K = PROD_W'(128);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LUMA      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_CHROMA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LSPREAD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_CSPREAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_LUMA     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_CHROMA   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_LSPREAD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_CSPREAD  = 3'd7;

  // Register groups shared by the channels.
  localparam logic [GRP_W-1:0] GRP_LUMA    = 2'd0;
  localparam logic [GRP_W-1:0] GRP_CHROMA  = 2'd1;
  localparam logic [GRP_W-1:0] GRP_LSPREAD = 2'd2;
  localparam logic [GRP_W-1:0] GRP_CSPREAD = 2'd3;

  localparam logic [1:0] MODE_THREE   = 2'd0;
  localparam logic [1:0] MODE_FOUR    = 2'd1;
  localparam logic [1:0] MODE_SIX     = 2'd2;
  localparam logic [1:0] MODE_SIX_ALT = 2'd3;

  localparam logic [CH_W-1:0] LAST_CH_THREE = 3'd2;
  localparam logic [CH_W-1:0] LAST_CH_FOUR  = 3'd3;
  localparam logic [CH_W-1:0] LAST_CH_SIX   = 3'd5;

  localparam logic [BYTE_W-1:0] VI2_TAG   = 8'h80;
  localparam logic [BYTE_W-1:0] VI3_TAG   = 8'hC0;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [PRED_W-1:0] pred_t;
  typedef logic [Z_W-1:0]    z_t;
  typedef logic [CH_W-1:0]   ch_t;

  typedef struct packed {
    logic start;
    logic four;
    logic six;
  } emit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emit_stat_t;

  function automatic logic [GRP_W-1:0] chan_group(input ch_t ch);
    logic [GRP_W-1:0] g;
    unique case (ch) inside
      3'd0:       g = GRP_LUMA;
      3'd1, 3'd2: g = GRP_CHROMA;
      3'd3:       g = GRP_LSPREAD;
      default:    g = GRP_CSPREAD;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/delta_zigzag_varint_encoder.sv
// Top level of the delta, zigzag and varint block encoder: predictors,
// configuration registers and the channel sequencer. Depends on dzv_pkg,
// dzv_mul and dzv_emit.
//
// One block item is accepted when in_valid is high and in_stall low; the
// encoder then stalls its input while it works through the active channels
// (three, four or six, by mode) one at a time on a single shared multiplier,
// in these steps: scale the difference by the reciprocal, round and
// saturate, multiply the quantized delta by the step, update the predictor.
// The encoded bytes (one to nineteen) then leave one per cycle through the
// output register while out_stall is low, the final byte flagged by out_last.
// The next item is taken while the final byte still waits in the output
// register. Step and reciprocal registers must only be written while idle.
module delta_zigzag_varint_encoder import dzv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_mode,
  input  logic                 in_restart,
  input  logic [VAL_W-1:0]     in_luma_avg,
  input  logic [VAL_W-1:0]     in_u_avg,
  input  logic [VAL_W-1:0]     in_v_avg,
  input  logic [VAL_W-1:0]     in_luma_spread,
  input  logic [VAL_W-1:0]     in_u_spread,
  input  logic [VAL_W-1:0]     in_v_spread,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULD  = 3'd1;
  localparam logic [2:0] ST_QUANT = 3'd2;
  localparam logic [2:0] ST_MULS  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;
  ch_t                   ch_r;
  ch_t                   lastch_r;
  logic                  four_r;
  logic                  six_r;
  val_t                  val_r   [CH_N];
  pred_t                 pred_r  [CH_N];
  z_t [CH_N-1:0]         z_r;
  logic signed [Q_W-1:0] q_r;
  logic [STEP_W-1:0]     step_r  [GRP_N];
  logic [RECIP_W-1:0]    recip_r [GRP_N];

  logic                     accept;
  logic [GRP_W-1:0]         grp;
  pred_t                    cur_pred;
  val_t                     cur_val;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] mul_a;
  logic [RECIP_W-1:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [SHIFT_W-1:0] scaled;
  logic signed [Q_W-1:0]    qsat;
  z_t                       zz;
  ch_t                      lastch_in;
  logic                     four_in;
  logic                     six_in;
  emit_req_t                emit_req;
  emit_stat_t               emit_stat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign grp      = chan_group(ch_r);
  assign cur_pred = pred_r[ch_r];
  assign cur_val  = val_r[ch_r];
  assign diff     = $signed({{(DIFF_W - VAL_W){1'b0}}, cur_val}) -
                    $signed({{(DIFF_W - PRED_W){cur_pred[PRED_W-1]}}, cur_pred});

  assign mul_a = (state_r == ST_MULS) ? q_r : diff;
  assign mul_b = (state_r == ST_MULS) ? {1'b0, step_r[grp]} : recip_r[grp];

  dzv_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // An arithmetic shift floors, which matches rounding towards minus infinity.
  assign rounded = prod + ROUND_K;
  assign scaled  = rounded[PROD_W-1:8];

  always_comb begin
    if (scaled[SHIFT_W-1:Q_W-1] == '0 || scaled[SHIFT_W-1:Q_W-1] == '1) begin
      qsat = scaled[Q_W-1:0];
    end else if (scaled[SHIFT_W-1]) begin
      qsat = {1'b1, {(Q_W - 1){1'b0}}};
    end else begin
      qsat = {1'b0, {(Q_W - 1){1'b1}}};
    end
  end

  assign zz = {qsat[Q_W-2:0], 1'b0} ^ {Z_W{qsat[Q_W-1]}};

  always_comb begin
    unique case (in_mode) inside
      MODE_THREE: begin
        lastch_in = LAST_CH_THREE;
        four_in   = 1'b0;
        six_in    = 1'b0;
      end
      MODE_FOUR: begin
        lastch_in = LAST_CH_FOUR;
        four_in   = 1'b1;
        six_in    = 1'b0;
      end
      MODE_SIX, MODE_SIX_ALT: begin
        lastch_in = LAST_CH_SIX;
        four_in   = 1'b1;
        six_in    = 1'b1;
      end
      default: begin
        lastch_in = LAST_CH_THREE;
        four_in   = 1'b0;
        six_in    = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_MULD;
      ST_MULD:  state_nxt = ST_QUANT;
      ST_QUANT: state_nxt = ST_MULS;
      ST_MULS:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = (ch_r == lastch_r) ? ST_EMIT : ST_MULD;
      ST_EMIT:  if (emit_stat.done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign emit_req.start = (state_r == ST_UPD) && (ch_r == lastch_r);
  assign emit_req.four  = four_r;
  assign emit_req.six   = six_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
      for (int i = 0; i < CH_N; i++) begin
        pred_r[i] <= '0;
      end
      for (int g = 0; g < GRP_N; g++) begin
        step_r[g]  <= STEP_W'(1);
        recip_r[g] <= RECIP_W'(256);
      end
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        ch_r <= '0;
        if (in_restart) begin
          for (int i = 0; i < CH_N; i++) begin
            pred_r[i] <= '0;
          end
        end
      end else if (state_r == ST_UPD) begin
        pred_r[ch_r] <= cur_pred + prod[PRED_W-1:0];
        ch_r         <= ch_r + CH_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP_LUMA:     step_r[GRP_LUMA]     <= cfg_data[STEP_W-1:0];
          REG_STEP_CHROMA:   step_r[GRP_CHROMA]   <= cfg_data[STEP_W-1:0];
          REG_STEP_LSPREAD:  step_r[GRP_LSPREAD]  <= cfg_data[STEP_W-1:0];
          REG_STEP_CSPREAD:  step_r[GRP_CSPREAD]  <= cfg_data[STEP_W-1:0];
          REG_RECIP_LUMA:    recip_r[GRP_LUMA]    <= cfg_data;
          REG_RECIP_CHROMA:  recip_r[GRP_CHROMA]  <= cfg_data;
          REG_RECIP_LSPREAD: recip_r[GRP_LSPREAD] <= cfg_data;
          REG_RECIP_CSPREAD: recip_r[GRP_CSPREAD] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Channels left out by the mode keep a zero zigzag value, so the
  // formatter can look at all six without knowing which are active.
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r[0] <= in_luma_avg;
      val_r[1] <= in_u_avg;
      val_r[2] <= in_v_avg;
      val_r[3] <= in_luma_spread;
      val_r[4] <= in_u_spread;
      val_r[5] <= in_v_spread;
      lastch_r <= lastch_in;
      four_r   <= four_in;
      six_r    <= six_in;
      z_r      <= '0;
    end else if (state_r == ST_QUANT) begin
      q_r        <= qsat;
      z_r[ch_r]  <= zz;
    end
  end

  dzv_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (emit_req),
    .z         (z_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .stat      (emit_stat)
  );

  a_accept_starts_first_channel: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_MULD && ch_r == '0)
    else $error("transaction accepted without starting at the first channel");

  a_idle_means_formatter_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !emit_stat.busy)
    else $error("input ready while the formatter still has bytes to send");

  a_finish_leaves_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && emit_stat.done |=> out_valid && out_last)
    else $error("item finished without a final byte in the output register");

  a_start_after_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.start |-> !emit_stat.busy && ch_r == lastch_r)
    else $error("formatter started before all channels were quantized");

endmodule

FILE: rtl/dzv_mul.sv
// Shared signed multiplier with a registered product, used for both the
// delta scaling and the predictor step. Depends on dzv_pkg.
module dzv_mul import dzv_pkg::*; (
  input  logic                     clk,
  input  logic signed [DIFF_W-1:0] op_a,
  input  logic [RECIP_W-1:0]       op_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;

  assign prod_nxt = PROD_W'($signed(op_a) * $signed({1'b0, op_b}));

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

FILE: rtl/dzv_emit.sv
// Byte formatter and output register: turns the six zigzag values into a
// zero byte, a packed word or a mask byte with varints. Depends on dzv_pkg.
module dzv_emit import dzv_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  emit_req_t           req,
  input  z_t [CH_N-1:0]       z,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_last,
  output emit_stat_t          stat
);

  localparam logic [1:0] FMT_ZERO = 2'd0;
  localparam logic [1:0] FMT_PACK = 2'd1;
  localparam logic [1:0] FMT_VAR  = 2'd2;

  typedef struct packed {
    logic found;
    ch_t  idx;
  } pick_t;

  // Lowest set bit of the mask at or above the given channel.
  function automatic pick_t first_set(input logic [CH_N-1:0] m, input ch_t from);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = CH_N - 1; i >= 0; i--) begin
      if (m[i] && (CH_W'(i) >= from)) begin
        p.found = 1'b1;
        p.idx   = CH_W'(i);
      end
    end
    return p;
  endfunction

  logic              busy_r;
  logic [1:0]        fmt_r;
  logic [1:0]        lastb_r;
  logic [1:0]        bi_r;
  logic              hdr_r;
  ch_t               ech_r;
  logic [1:0]        eb_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic [CH_N-1:0]   nzmask;
  logic              anyz;
  logic              fits5;
  logic [31:0]       word;
  pick_t             first_pick;
  pick_t             next_pick;
  z_t                zc;
  logic [1:0]        vlen;
  logic [1:0]        vrem;
  logic [BYTE_W-1:0] vbyte;
  logic              vend;
  logic              advance;
  logic [BYTE_W-1:0] byte_nxt;
  logic              last_nxt;

  always_comb begin
    fits5 = 1'b1;
    for (int i = 0; i < CH_N; i++) begin
      nzmask[i] = |z[i];
      if (|z[i][Z_W-1:SMALL_W]) begin
        fits5 = 1'b0;
      end
    end
  end

  assign anyz = |nzmask;

  // Inactive channels hold zero, so their fields add nothing to the word.
  assign word = {z[5][4:0], z[4][4:0], req.six, z[3][4:0],
                 z[2][4:0], z[1][4:0], z[0][4:0], 1'b1};

  assign first_pick = first_set(nzmask, '0);
  assign next_pick  = first_set(nzmask, ech_r + CH_W'(1));

  assign zc = z[ech_r];

  always_comb begin
    if (zc[Z_W-1:7] == '0) begin
      vlen = 2'd1;
    end else if (zc[Z_W-1:14] == '0) begin
      vlen = 2'd2;
    end else begin
      vlen = 2'd3;
    end
  end

  assign vrem = vlen - 2'd1 - eb_r;
  assign vend = (eb_r == vlen - 2'd1);

  always_comb begin
    case (vrem)
      2'd0:    vbyte = zc[7:0];
      2'd1:    vbyte = (vlen == 2'd2) ? (VI2_TAG | {2'b00, zc[13:8]}) : zc[15:8];
      default: vbyte = VI3_TAG | {3'b000, zc[20:16]};
    endcase
  end

  always_comb begin
    unique case (fmt_r)
      FMT_ZERO: begin
        byte_nxt = ZERO_BYTE;
        last_nxt = 1'b1;
      end
      FMT_PACK: begin
        byte_nxt = BYTE_W'(word >> {bi_r, 3'b000});
        last_nxt = (bi_r == lastb_r);
      end
      FMT_VAR: begin
        if (hdr_r) begin
          byte_nxt = {1'b0, nzmask, 1'b0};
          last_nxt = 1'b0;
        end else begin
          byte_nxt = vbyte;
          last_nxt = vend && !next_pick.found;
        end
      end
      default: begin
        byte_nxt = ZERO_BYTE;
        last_nxt = 1'b1;
      end
    endcase
  end

  assign advance = busy_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      hdr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        hdr_r  <= anyz && !fits5;
      end else if (advance) begin
        if (last_nxt) begin
          busy_r <= 1'b0;
        end
        hdr_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (!anyz) begin
        fmt_r <= FMT_ZERO;
      end else if (fits5) begin
        fmt_r <= FMT_PACK;
      end else begin
        fmt_r <= FMT_VAR;
      end
      lastb_r <= req.six ? 2'd3 : (req.four ? 2'd2 : 2'd1);
      bi_r    <= '0;
      ech_r   <= first_pick.idx;
      eb_r    <= '0;
    end else if (advance) begin
      bi_r <= bi_r + 2'd1;
      if (fmt_r == FMT_VAR && !hdr_r) begin
        if (vend) begin
          ech_r <= next_pick.idx;
          eb_r  <= '0;
        end else begin
          eb_r <= eb_r + 2'd1;
        end
      end
    end
    if (advance) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign stat.busy = busy_r;
  assign stat.done = advance && last_nxt;

  a_var_points_at_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && fmt_r == FMT_VAR && !hdr_r |-> nzmask[ech_r])
    else $error("varint channel pointer rests on a zero channel");

  a_hdr_only_in_var: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_r |-> busy_r && fmt_r == FMT_VAR)
    else $error("mask byte pending outside varint format");

  a_pack_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && fmt_r == FMT_PACK |-> bi_r <= lastb_r)
    else $error("packed word byte index ran past its length");

endmodule

FILE: tb/sv/delta_zigzag_varint_encoder_tb.sv
// Self-checking testbench for delta_zigzag_varint_encoder: directed and random block
// transactions with a byte-level prediction of the encoded stream.
// Depends on dzv_pkg and the encoder RTL only.
module delta_zigzag_varint_encoder_tb import dzv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 8;
  localparam int ITEMS_PER_PHASE = 25;
  localparam longint VARINT1_LIM = 'h80;
  localparam longint VARINT2_LIM = 'h4000;
  localparam longint QSAT_HI = (1 << 20) - 1;
  localparam longint QSAT_LO = -(1 << 20);

  typedef struct packed {
    logic [1:0]            mode;
    logic                  restart;
    val_t [CH_N-1:0]       v;
  } blk_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } enc_byte_t;

  function automatic int grp_of_channel(input int c);
    if (c == 0) return int'(GRP_LUMA);
    if (c < 3) return int'(GRP_CHROMA);
    if (c == 3) return int'(GRP_LSPREAD);
    return int'(GRP_CSPREAD);
  endfunction

  // Holds the encoder's register and predictor state and the bytes still owed.
  class byte_stream_checker;
    logic [STEP_W-1:0]  step [GRP_N];
    logic [RECIP_W-1:0] recip [GRP_N];
    pred_t              pred [CH_N];
    enc_byte_t          expected_bytes [$];
    int                 errors;

    function new();
      for (int g = 0; g < GRP_N; g++) begin
        step[g] = STEP_W'(1);
        recip[g] = RECIP_W'(256);
      end
      for (int c = 0; c < CH_N; c++) pred[c] = '0;
      errors = 0;
    endfunction

    // Step and reciprocal indexes share their low bits with the group number.
    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      if (idx <= REG_STEP_CSPREAD) step[idx[GRP_W-1:0]] = data[STEP_W-1:0];
      else recip[idx[GRP_W-1:0]] = data[RECIP_W-1:0];
    endfunction

    function void add(input logic [BYTE_W-1:0] d);
      expected_bytes.push_back('{data: d, last: 1'b0});
    endfunction

    function void add_varint(input z_t z);
      if (z < VARINT1_LIM) begin
        add(z[7:0]);
      end else if (z < VARINT2_LIM) begin
        add(VI2_TAG | z[15:8]);
        add(z[7:0]);
      end else begin
        add(VI3_TAG | {3'b000, z[20:16]});
        add(z[15:8]);
        add(z[7:0]);
      end
    endfunction

    // Predicts the bytes of one accepted block transaction and advances the predictors.
    function void note_block(input blk_t b);
      int nch, c, nb;
      longint d, p, r, s, t;
      longint q [CH_N];
      z_t z [CH_N];
      z_t any_z;
      logic [31:0] w;
      logic [BYTE_W-1:0] mask;
      nch = b.mode[1] ? 6 : ((b.mode == MODE_FOUR) ? 4 : 3);
      if (b.restart)
        for (c = 0; c < CH_N; c++) pred[c] = '0;
      any_z = '0;
      for (c = 0; c < nch; c++) begin
        p = $signed(pred[c]);
        d = longint'(b.v[c]) - p;
        r = recip[grp_of_channel(c)];
        t = d * r + 128;
        q[c] = t >>> 8;
        if (q[c] > QSAT_HI) q[c] = QSAT_HI;
        if (q[c] < QSAT_LO) q[c] = QSAT_LO;
        if (q[c] >= 0) z[c] = z_t'(2 * q[c]);
        else z[c] = z_t'(-2 * q[c] - 1);
        any_z |= z[c];
      end
      if (any_z == '0) begin
        add(ZERO_BYTE);
      end else if (any_z[Z_W-1:SMALL_W] == '0) begin
        w = '0;
        w[0] = 1'b1;
        w[5:1] = z[0][4:0];
        w[10:6] = z[1][4:0];
        w[15:11] = z[2][4:0];
        nb = 2;
        if (nch >= 4) begin
          w[20:16] = z[3][4:0];
          nb = 3;
        end
        if (nch == 6) begin
          w[21] = 1'b1;
          w[26:22] = z[4][4:0];
          w[31:27] = z[5][4:0];
          nb = 4;
        end
        for (c = 0; c < nb; c++) add(w[8*c +: 8]);
      end else begin
        mask = '0;
        for (c = 0; c < nch; c++)
          if (q[c] != 0) mask[c+1] = 1'b1;
        add(mask);
        for (c = 0; c < nch; c++)
          if (q[c] != 0) add_varint(z[c]);
      end
      expected_bytes[expected_bytes.size()-1].last = 1'b1;
      for (c = 0; c < nch; c++) begin
        s = step[grp_of_channel(c)];
        pred[c] = pred[c] + pred_t'(q[c] * s);
      end
    endfunction

    function void check_byte(input logic [BYTE_W-1:0] data, input logic last);
      enc_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output transaction: out_byte %02h, out_last %0b", data, last);
        errors++;
      end else begin
        e = expected_bytes.pop_front();
        if (data !== e.data) begin
          $error("out_byte: expected %02h, got %02h", e.data, data);
          errors++;
        end
        if (last !== e.last) begin
          $error("out_last: expected %0b, got %0b", e.last, last);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_mode = MODE_THREE;
  logic                 in_restart = 1'b0;
  logic [VAL_W-1:0]     in_luma_avg = '0;
  logic [VAL_W-1:0]     in_u_avg = '0;
  logic [VAL_W-1:0]     in_v_avg = '0;
  logic [VAL_W-1:0]     in_luma_spread = '0;
  logic [VAL_W-1:0]     in_u_spread = '0;
  logic [VAL_W-1:0]     in_v_spread = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_LUMA;
  logic [CFG_W-1:0]     cfg_data = '0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;
  byte_stream_checker sb = new();

  delta_zigzag_varint_encoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_restart(in_restart),
    .in_luma_avg(in_luma_avg), .in_u_avg(in_u_avg), .in_v_avg(in_v_avg),
    .in_luma_spread(in_luma_spread), .in_u_spread(in_u_spread),
    .in_v_spread(in_v_spread),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A long hold-off takes priority over the random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_byte(out_byte, out_last);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("delta_zigzag_varint_encoder regression: fail");
    $finish;
  end

  function automatic blk_t make_block(input logic [1:0] mode, input logic restart,
                                      input int a, b, c, d, e, f);
    blk_t blk;
    blk.mode = mode;
    blk.restart = restart;
    blk.v[0] = val_t'(a);
    blk.v[1] = val_t'(b);
    blk.v[2] = val_t'(c);
    blk.v[3] = val_t'(d);
    blk.v[4] = val_t'(e);
    blk.v[5] = val_t'(f);
    return blk;
  endfunction

  // Most blocks sit close to the current predictors so that the zero and packed
  // forms turn up often; the rest are wider deltas and raw values.
  function automatic blk_t random_block();
    blk_t b;
    int kind, c;
    longint p, r, v;
    b.mode = 2'($urandom_range(3));
    b.restart = ($urandom_range(99) < 5);
    kind = $urandom_range(99);
    for (c = 0; c < CH_N; c++) begin
      p = $signed(sb.pred[c]);
      r = sb.recip[grp_of_channel(c)];
      if (r == 0) r = 1;
      if (kind < 20)
        v = p;
      else if (kind < 55)
        v = p + (longint'($urandom_range(33)) - 17) * 256 / r;
      else if (kind < 80)
        v = p + longint'($urandom_range(4000)) - 2000;
      else begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = 65535;
          default: v = $urandom_range(65535);
        endcase
      end
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      b.v[c] = val_t'(v);
    end
    return b;
  endfunction

  task automatic offer(input blk_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= b.mode;
    in_restart <= b.restart;
    in_luma_avg <= b.v[0];
    in_u_avg <= b.v[1];
    in_v_avg <= b.v[2];
    in_luma_spread <= b.v[3];
    in_u_spread <= b.v[4];
    in_v_spread <= b.v[5];
    do @(posedge clk); while (in_stall);
    sb.note_block(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input int ls, cs, lss, css, lr, cr, lsr, csr);
    logic [CFG_IDX_W-1:0] idx [8];
    int vals [8];
    idx = '{REG_STEP_LUMA, REG_STEP_CHROMA, REG_STEP_LSPREAD, REG_STEP_CSPREAD,
            REG_RECIP_LUMA, REG_RECIP_CHROMA, REG_RECIP_LSPREAD, REG_RECIP_CSPREAD};
    vals = '{ls, cs, lss, css, lr, cr, lsr, csr};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= CFG_W'(vals[i]);
      @(posedge clk);
      sb.set_reg(idx[i], CFG_W'(vals[i]));
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int ph;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_settings(1, 1, 1, 1, 256, 256, 256, 256);
    offer(make_block(MODE_THREE, 1'b0, 0, 0, 0, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 15, 0, 3, 0, 0, 0));
    offer(make_block(MODE_FOUR, 1'b0, 0, 15, 3, 9, 0, 0));
    offer(make_block(MODE_SIX, 1'b0, 15, 15, 3, 9, 7, 15));
    offer(make_block(MODE_SIX_ALT, 1'b0, 15, 15, 3, 9, 7, 0));
    offer(make_block(MODE_THREE, 1'b0, 55, 1015, 65535, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 55, 1015, 65535, 0, 0, 0));
    offer(make_block(MODE_SIX, 1'b0, 65535, 65535, 65535, 65535, 65535, 65535));
    // Restart with every channel at full scale gives the longest stream.
    offer(make_block(MODE_SIX, 1'b1, 65535, 65535, 65535, 65535, 65535, 65535));
    offer(make_block(MODE_SIX, 1'b0, 0, 0, 0, 0, 0, 0));
    offer(make_block(MODE_SIX, 1'b1, 0, 0, 0, 0, 0, 0));
    offer(make_block(MODE_FOUR, 1'b0, 0, 0, 0, 65535, 0, 0));
    // Zigzag values either side of the packed and varint length boundaries.
    offer(make_block(MODE_THREE, 1'b0, 16, 0, 0, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 0, 0, 0, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 64, 0, 0, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 0, 0, 0, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 8192, 0, 0, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 0, 0, 0, 0, 0, 0));

    // A coarse luma step drives the predictor past its wrap point, after which
    // the largest reciprocal saturates the quantised delta.
    drain();
    apply_settings(8, 1, 1, 1, 256, 256, 256, 256);
    offer(make_block(MODE_THREE, 1'b0, 65535, 0, 0, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 0, 0, 0, 0, 0, 0));
    drain();
    apply_settings(8, 1, 1, 1, 511, 256, 256, 256);
    offer(make_block(MODE_THREE, 1'b0, 65535, 0, 0, 0, 0, 0));

    drain();
    apply_settings(1, 0, 1, 1, 0, 256, 256, 256);
    offer(make_block(MODE_THREE, 1'b0, 1234, 4321, 999, 0, 0, 0));
    offer(make_block(MODE_THREE, 1'b0, 1234, 4321, 999, 0, 0, 0));

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: apply_settings(1, 1, 1, 1, 256, 256, 256, 256);
        1: apply_settings('h1FF, 'h1FF, 'h1FF, 'h1FF, 1, 1, 1, 1);
        3: apply_settings(0, 255, 1, 0, 0, 511, 256, 1);
        4: apply_settings(1, 1, 1, 1, 511, 511, 511, 511);
        5: apply_settings($urandom_range(511), $urandom_range(511), $urandom_range(511),
                          $urandom_range(511), $urandom_range(511), $urandom_range(511),
                          $urandom_range(511), $urandom_range(511));
        6: apply_settings(16, 16, 16, 16, 16, 16, 16, 16);
        default: apply_settings($urandom_range(1, 255), $urandom_range(1, 255),
                                $urandom_range(1, 255), $urandom_range(1, 255),
                                $urandom_range(1, 256), $urandom_range(1, 256),
                                $urandom_range(1, 256), $urandom_range(1, 256));
      endcase
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 61;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 61;
        end
        default: begin
          sender_idle_pct = 38;
          receiver_stall_pct = 38;
        end
      endcase
      // The receiver holds off while blocks keep coming, so the encoder backs up.
      if (ph == 0) hold_left = HOLD_CYCLES;
      repeat (ITEMS_PER_PHASE) offer(random_block());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("delta_zigzag_varint_encoder regression: pass");
    else
      $display("delta_zigzag_varint_encoder regression: fail");
    $finish;
  end

endmodule
